@@ rtl/upv_pkg.sv @@
// Package for the UTF-8 path validator: widths, byte codes and character class helpers.
package upv_pkg;

    localparam int unsigned MaxPathBytesDefault = 4096;
    localparam int unsigned LenW                = 13;
    localparam int unsigned InDataW             = 8;
    localparam int unsigned OutDataW            = 16;

    // Byte codes used by the path and UTF-8 rules.
    localparam logic [7:0] ByteNul      = 8'h00;
    localparam logic [7:0] ByteSlash    = 8'h2F;
    localparam logic [7:0] ByteDot      = 8'h2E;
    localparam logic [7:0] ByteSpace    = 8'h20;
    localparam logic [7:0] ByteDel      = 8'h7F;
    localparam logic [7:0] ByteAsciiTop = 8'h80;
    localparam logic [7:0] Lead2Low     = 8'hC2;
    localparam logic [7:0] Lead2High    = 8'hDF;
    localparam logic [7:0] Lead3Low     = 8'hE0;
    localparam logic [7:0] Lead3High    = 8'hEF;
    localparam logic [7:0] Lead4Low     = 8'hF0;
    localparam logic [7:0] Lead4High    = 8'hF4;
    localparam logic [7:0] LeadSurr     = 8'hED;
    localparam logic [7:0] ContMask     = 8'hC0;
    localparam logic [7:0] ContTag      = 8'h80;
    localparam logic [7:0] Cont9F       = 8'h9F;
    localparam logic [7:0] ContA0       = 8'hA0;
    localparam logic [7:0] Cont90       = 8'h90;
    localparam logic [7:0] Cont8F       = 8'h8F;

    localparam logic [1:0] SegLenMax    = 2'd3;

    function automatic logic byte_forbidden(input logic [7:0] b);
        logic hit;
        case (b)
            8'h5C, 8'h2A, 8'h3F, 8'h5B, 8'h5D, 8'h7B, 8'h7D, ByteDel: hit = 1'b1;
            default: hit = (b < ByteSpace);
        endcase
        return hit;
    endfunction

    // Range check on the second byte of a sequence, keyed by its lead byte.
    function automatic logic first_cont_bad(input logic [7:0] lead, input logic [7:0] b);
        return (lead == Lead3Low  && b <  ContA0) ||
               (lead == LeadSurr  && b >  Cont9F) ||
               (lead == Lead4Low  && b <  Cont90) ||
               (lead == Lead4High && b >  Cont8F) ||
               (lead == Lead2Low  && b <= Cont9F);
    endfunction

endpackage

@@ rtl/utf8_path_validator.sv @@
// UTF-8 path validator: checks a zero-terminated byte stream and gives one verdict per path.
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] path_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata[0] path_valid, [13:1] path_length
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data absolute_mode
//
// One byte is taken per cycle unless stalled; the per-byte rules are a single level of
// compares that update the path state registers directly. A terminator loads the
// verdict into the output register, seen in the cycle after its transfer. Input is
// stalled only while a verdict waits in the output register and m_tready is low. Reset
// is synchronous and active low; it clears path state, mode register and output valid.
module utf8_path_validator #(
    parameter int unsigned MAX_PATH_BYTES = upv_pkg::MaxPathBytesDefault
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [upv_pkg::InDataW-1:0]  s_tdata,   // [7:0] path_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [upv_pkg::OutDataW-1:0] m_tdata    // [0] path_valid, [13:1] path_length, zeros
);

    localparam int unsigned CntW = $clog2(MAX_PATH_BYTES + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_PATH_BYTES);

    logic            abs_mode_reg;
    logic [CntW-1:0] count_reg,     count_next;
    logic [1:0]      rem_reg,       rem_next;
    logic [7:0]      lead_reg,      lead_next;
    logic            first_due_reg, first_due_next;
    logic [1:0]      seg_len_reg,   seg_len_next;
    logic            seg_dots_reg,  seg_dots_next;
    logic            err_reg,       err_next;

    logic                 m_valid_reg,  m_valid_next;
    logic                 verdict_reg,  verdict_next;
    logic [upv_pkg::LenW-1:0] length_reg, length_next;

    logic                 s_xfer;
    logic                 is_term;
    logic                 is_slash;
    logic                 first;
    logic                 seg_bad;
    logic [CntW+upv_pkg::LenW-1:0] count_ext;
    logic [7:0]           b;

    assign b        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign is_term  = (b == upv_pkg::ByteNul);
    assign is_slash = (b == upv_pkg::ByteSlash);
    assign first    = (count_reg == '0);
    assign seg_bad  = (seg_len_reg == 2'd0) || ((seg_len_reg <= 2'd2) && seg_dots_reg);
    assign count_ext = {{upv_pkg::LenW{1'b0}}, count_reg};

    always_comb begin
        count_next     = count_reg;
        rem_next       = rem_reg;
        lead_next      = lead_reg;
        first_due_next = first_due_reg;
        seg_len_next   = seg_len_reg;
        seg_dots_next  = seg_dots_reg;
        err_next       = err_reg;
        verdict_next   = verdict_reg;
        length_next    = length_reg;

        if (s_xfer && is_term) begin
            if (first || err_reg || rem_reg != 2'd0) begin
                verdict_next = 1'b0;
            end else if (abs_mode_reg && count_reg == CntW'(1)) begin
                verdict_next = 1'b1;
            end else begin
                verdict_next = !seg_bad;
            end
            length_next    = count_ext[upv_pkg::LenW-1:0];
            count_next     = '0;
            rem_next       = 2'd0;
            lead_next      = 8'd0;
            first_due_next = 1'b0;
            seg_len_next   = 2'd0;
            seg_dots_next  = 1'b1;
            err_next       = 1'b0;
        end else if (s_xfer) begin
            if (count_reg == CntMax) begin
                err_next = 1'b1;
            end else begin
                count_next = count_reg + CntW'(1);
            end
            if (first && (abs_mode_reg != is_slash)) begin
                err_next = 1'b1;
            end
            if (upv_pkg::byte_forbidden(b)) begin
                err_next = 1'b1;
            end

            // UTF-8 sequence tracking.
            if (rem_reg == 2'd0) begin
                if (b >= upv_pkg::ByteAsciiTop) begin
                    if (b >= upv_pkg::Lead2Low && b <= upv_pkg::Lead2High) begin
                        rem_next = 2'd1;
                    end else if (b >= upv_pkg::Lead3Low && b <= upv_pkg::Lead3High) begin
                        rem_next = 2'd2;
                    end else if (b >= upv_pkg::Lead4Low && b <= upv_pkg::Lead4High) begin
                        rem_next = 2'd3;
                    end else begin
                        err_next = 1'b1;
                    end
                    if (b >= upv_pkg::Lead2Low && b <= upv_pkg::Lead4High) begin
                        lead_next      = b;
                        first_due_next = 1'b1;
                    end
                end
            end else if ((b & upv_pkg::ContMask) != upv_pkg::ContTag) begin
                // A broken sequence is dropped; the byte is not taken as a new lead.
                err_next       = 1'b1;
                rem_next       = 2'd0;
                first_due_next = 1'b0;
            end else begin
                if (first_due_reg) begin
                    if (upv_pkg::first_cont_bad(lead_reg, b)) begin
                        err_next = 1'b1;
                    end
                    first_due_next = 1'b0;
                end
                rem_next = rem_reg - 2'd1;
            end

            // Segment rules; the leading slash of an absolute path opens no segment.
            if (!(first && abs_mode_reg && is_slash)) begin
                if (is_slash) begin
                    if (seg_bad) begin
                        err_next = 1'b1;
                    end
                    seg_len_next  = 2'd0;
                    seg_dots_next = 1'b1;
                end else begin
                    if (seg_len_reg < upv_pkg::SegLenMax) begin
                        seg_len_next = seg_len_reg + 2'd1;
                    end
                    if (b != upv_pkg::ByteDot) begin
                        seg_dots_next = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        if (s_xfer && is_term) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_mode_reg  <= 1'b0;
            count_reg     <= '0;
            rem_reg       <= 2'd0;
            lead_reg      <= 8'd0;
            first_due_reg <= 1'b0;
            seg_len_reg   <= 2'd0;
            seg_dots_reg  <= 1'b1;
            err_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                abs_mode_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            lead_reg      <= lead_next;
            first_due_reg <= first_due_next;
            seg_len_reg   <= seg_len_next;
            seg_dots_reg  <= seg_dots_next;
            err_reg       <= err_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
        length_reg  <= length_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(upv_pkg::OutDataW - upv_pkg::LenW - 1){1'b0}}, length_reg, verdict_reg};

    // The byte count never passes the configured limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntMax)
        else $error("byte count above limit");

    // A pending first-continuation check implies an open sequence.
    a_first_due_open: assert property (@(posedge aclk) disable iff (!aresetn)
        first_due_reg |-> (rem_reg != 2'd0))
        else $error("first continuation due without open sequence");

    // A terminator transfer yields a verdict and a cleared path state.
    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && is_term) |=> (m_tvalid && count_reg == '0 && !err_reg && rem_reg == 2'd0))
        else $error("terminator did not produce verdict and clear state");

    // A non-terminator below the limit advances the count by one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !is_term && count_reg != CntMax) |=>
            (count_reg == $past(count_reg) + CntW'(1)))
        else $error("byte count did not advance");

    // Input is never taken while a verdict is stalled.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted over a stalled verdict");

endmodule

@@ bench/utf8_path_validator_tb.sv @@
// Self-checking testbench for the UTF-8 path validator: directed and random paths under random flow control.
`timescale 1ns / 1ps

module utf8_path_validator_tb;

    localparam int unsigned QuietLimit = 5000;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned RandomBytes = 1600;
    localparam int unsigned PhaseBytes = 200;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic                         cfg_wr_data = 1'b0;
    logic                         s_tvalid    = 1'b0;
    logic                         s_tready;
    logic [upv_pkg::InDataW-1:0]  s_tdata     = '0;
    logic                         m_tvalid;
    logic                         m_tready    = 1'b0;
    logic [upv_pkg::OutDataW-1:0] m_tdata;

    utf8_path_validator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Tracks the path rules byte by byte and holds the verdicts still owed by the block.
    class path_verdict_board;
        typedef struct packed {
            logic                     ok;
            logic [upv_pkg::LenW-1:0] len;
        } verdict_t;

        verdict_t    due_q[$];
        int unsigned mismatches;
        int unsigned max_len;
        bit          abs_mode;
        int unsigned byte_count;
        int unsigned utf8_left;
        logic [7:0]  utf8_lead;
        bit          first_cont;
        int unsigned seg_len;
        bit          seg_dots;
        bit          err;

        function new(int unsigned limit);
            max_len    = limit;
            mismatches = 0;
            abs_mode   = 1'b0;
            clear_path();
        endfunction

        function void clear_path();
            byte_count = 0;
            utf8_left  = 0;
            utf8_lead  = '0;
            first_cont = 1'b0;
            seg_len    = 0;
            seg_dots   = 1'b1;
            err        = 1'b0;
        endfunction

        function void set_mode(bit mode);
            abs_mode = mode;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        function bit banned_byte(logic [7:0] b);
            string specials;
            bit    hit;
            specials = "\\*?[]{}";
            hit = (b < upv_pkg::ByteSpace) || (b == upv_pkg::ByteDel);
            for (int i = 0; i < specials.len(); i++) begin
                if (b == specials[i]) hit = 1'b1;
            end
            return hit;
        endfunction

        function bit segment_broken();
            return (seg_len == 0) || (seg_len <= 2 && seg_dots);
        endfunction

        function void utf8_take(logic [7:0] b);
            if (utf8_left == 0) begin
                if (b < upv_pkg::ByteAsciiTop) return;
                if (b >= upv_pkg::Lead2Low && b <= upv_pkg::Lead2High) begin
                    utf8_left = 1;
                end else if (b >= upv_pkg::Lead3Low && b <= upv_pkg::Lead3High) begin
                    utf8_left = 2;
                end else if (b >= upv_pkg::Lead4Low && b <= upv_pkg::Lead4High) begin
                    utf8_left = 3;
                end else begin
                    err = 1'b1;
                    return;
                end
                utf8_lead  = b;
                first_cont = 1'b1;
                return;
            end
            // A byte that is not a continuation ends the sequence and is not taken as a lead.
            if ((b & upv_pkg::ContMask) != upv_pkg::ContTag) begin
                err        = 1'b1;
                utf8_left  = 0;
                first_cont = 1'b0;
                return;
            end
            if (first_cont) begin
                case (utf8_lead)
                    upv_pkg::Lead3Low:  if (b < upv_pkg::ContA0) err = 1'b1;
                    upv_pkg::LeadSurr:  if (b > upv_pkg::Cont9F) err = 1'b1;
                    upv_pkg::Lead4Low:  if (b < upv_pkg::Cont90) err = 1'b1;
                    upv_pkg::Lead4High: if (b > upv_pkg::Cont8F) err = 1'b1;
                    upv_pkg::Lead2Low:  if (b <= upv_pkg::Cont9F) err = 1'b1;
                    default: ;
                endcase
                first_cont = 1'b0;
            end
            utf8_left--;
        endfunction

        function void note_byte(logic [7:0] b);
            bit       first;
            verdict_t v;
            first = (byte_count == 0);
            if (b == upv_pkg::ByteNul) begin
                if (byte_count == 0 || err || utf8_left != 0) begin
                    v.ok = 1'b0;
                end else if (abs_mode && byte_count == 1) begin
                    v.ok = 1'b1;
                end else begin
                    v.ok = !segment_broken();
                end
                v.len = byte_count[upv_pkg::LenW-1:0];
                due_q.push_back(v);
                clear_path();
                return;
            end
            if (byte_count >= max_len) begin
                err = 1'b1;
            end else begin
                byte_count++;
            end
            if (first && (abs_mode != (b == upv_pkg::ByteSlash))) err = 1'b1;
            if (banned_byte(b)) err = 1'b1;
            utf8_take(b);
            // The root slash in absolute mode opens the first segment without closing one.
            if (first && abs_mode && b == upv_pkg::ByteSlash) return;
            if (b == upv_pkg::ByteSlash) begin
                if (segment_broken()) err = 1'b1;
                seg_len  = 0;
                seg_dots = 1'b1;
            end else begin
                if (seg_len < upv_pkg::SegLenMax) seg_len++;
                if (b != upv_pkg::ByteDot) seg_dots = 1'b0;
            end
        endfunction

        function void check_verdict(logic [upv_pkg::OutDataW-1:0] data);
            verdict_t want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict with none due: valid %0b length %0d",
                             $realtime, data[0], data[upv_pkg::LenW:1]);
                return;
            end
            want = due_q.pop_front();
            if (data[0] !== want.ok || data[upv_pkg::LenW:1] !== want.len) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict mismatch: valid exp %0b got %0b, length exp %0d got %0d",
                             $realtime, want.ok, data[0], want.len, data[upv_pkg::LenW:1]);
            end
        endfunction
    endclass

    path_verdict_board sb;
    logic [7:0]        path_q[$];
    int unsigned       quiet_cycles = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       burst_left = 0;
    bit                gap_off = 1'b0;
    bit                long_hold_req = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Transfers on all three ports are observed here so that a register write lands
    // after any byte accepted at the same edge, as it does in the block.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_byte(s_tdata);
        if (aresetn && cfg_wr_en) sb.set_mode(cfg_wr_data);
        if (aresetn && m_tvalid && m_tready) sb.check_verdict(m_tdata);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QuietLimit) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: a stall pattern that steps through four modes, plus one long hold-off.
    initial begin
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                long_hold_req = 1'b0;
            end else begin
                case ((cyc >> 8) & 3)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (cyc % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                cyc++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gap_off ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_path();
        foreach (path_q[i]) send_byte(path_q[i]);
    endtask

    task automatic send_text(input string s);
        path_q.delete();
        for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
        path_q.push_back(upv_pkg::ByteNul);
        send_path();
    endtask

    // The first edge lets the monitor note the transfer accepted at the last one.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input bit mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] cont_byte(input int unsigned lo, input int unsigned hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // Appends one well-formed character: mostly printable ASCII, some multibyte sequences
    // that keep within the edges of the legal lead and continuation ranges.
    function automatic void add_char();
        logic [7:0] lead;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            6: begin
                lead = cont_byte(upv_pkg::Lead2Low, upv_pkg::Lead2High);
                path_q.push_back(lead);
                if (lead == upv_pkg::Lead2Low)
                    path_q.push_back(cont_byte(8'hA0, 8'hBF));
                else
                    path_q.push_back(cont_byte(8'h80, 8'hBF));
            end
            7: begin
                lead = cont_byte(upv_pkg::Lead3Low, upv_pkg::Lead3High);
                path_q.push_back(lead);
                if (lead == upv_pkg::Lead3Low)
                    path_q.push_back(cont_byte(upv_pkg::ContA0, 8'hBF));
                else if (lead == upv_pkg::LeadSurr)
                    path_q.push_back(cont_byte(8'h80, upv_pkg::Cont9F));
                else
                    path_q.push_back(cont_byte(8'h80, 8'hBF));
                path_q.push_back(cont_byte(8'h80, 8'hBF));
            end
            8: begin
                lead = cont_byte(upv_pkg::Lead4Low, upv_pkg::Lead4High);
                path_q.push_back(lead);
                if (lead == upv_pkg::Lead4Low)
                    path_q.push_back(cont_byte(upv_pkg::Cont90, 8'hBF));
                else if (lead == upv_pkg::Lead4High)
                    path_q.push_back(cont_byte(8'h80, upv_pkg::Cont8F));
                else
                    path_q.push_back(cont_byte(8'h80, 8'hBF));
                path_q.push_back(cont_byte(8'h80, 8'hBF));
                path_q.push_back(cont_byte(8'h80, 8'hBF));
            end
            9: path_q.push_back(upv_pkg::ByteDot);
            default: begin
                do c = cont_byte(upv_pkg::ByteSpace, 8'h7E);
                while (sb.banned_byte(c) || c == upv_pkg::ByteSlash);
                path_q.push_back(c);
            end
        endcase
    endfunction

    function automatic void make_good_path(input bit abs_mode);
        int unsigned segs;
        path_q.delete();
        if (abs_mode) path_q.push_back(upv_pkg::ByteSlash);
        if (abs_mode && $urandom_range(0, 15) == 0) return;
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
            if (s > 0) path_q.push_back(upv_pkg::ByteSlash);
            repeat ($urandom_range(1, 6)) add_char();
        end
    endfunction

    function automatic void break_path();
        int unsigned n;
        int unsigned pos;
        n   = path_q.size();
        pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case ($urandom_range(0, 7))
            0: if (n > 0) path_q[pos] = cont_byte(1, 255);
            1: path_q.insert(pos, cont_byte(1, 255));
            2: if (n > 0) path_q.delete(pos);
            3: path_q.push_back(upv_pkg::ByteSlash);
            4: begin
                path_q.insert(pos, upv_pkg::ByteSlash);
                path_q.insert(pos, upv_pkg::ByteSlash);
            end
            5: begin
                path_q.push_back(upv_pkg::ByteSlash);
                path_q.push_back(upv_pkg::ByteDot);
                if ($urandom_range(0, 1) == 1) path_q.push_back(upv_pkg::ByteDot);
            end
            6: if (n > 0 && path_q[0] == upv_pkg::ByteSlash) path_q.delete(0);
               else path_q.push_front(upv_pkg::ByteSlash);
            default: if (n > 0) path_q.delete(n - 1);
        endcase
    endfunction

    function automatic void make_noise_path();
        path_q.delete();
        repeat ($urandom_range(0, 12)) path_q.push_back(cont_byte(0, 255));
    endfunction

    initial begin
        string       specials;
        int unsigned pick;
        int unsigned phase_start;
        bit          paused;

        sb = new(upv_pkg::MaxPathBytesDefault);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed paths, relative mode first.
        write_mode(1'b0);
        send_text("");
        send_text("a");
        send_text("/a");
        send_text("a/b");
        send_text("a/");
        send_text("a//b");
        send_text(".");
        send_text("..");
        send_text("...");
        send_text("a/../b");
        send_text(" ~");
        specials = "\\*?[]{}";
        for (int i = 0; i < specials.len(); i++) send_text(specials.substr(i, i));
        path_q = '{8'h1F, upv_pkg::ByteNul};                      send_path();
        path_q = '{upv_pkg::ByteDel, upv_pkg::ByteNul};           send_path();
        path_q = '{8'hC2, 8'h80, upv_pkg::ByteNul};               send_path();
        path_q = '{8'hC2, 8'hA0, upv_pkg::ByteNul};               send_path();
        path_q = '{8'hE0, 8'h9F, 8'h80, upv_pkg::ByteNul};        send_path();
        path_q = '{8'hE0, 8'hA0, 8'h80, upv_pkg::ByteNul};        send_path();
        path_q = '{8'hED, 8'hA0, 8'h80, upv_pkg::ByteNul};        send_path();
        path_q = '{8'hED, 8'h9F, 8'hBF, upv_pkg::ByteNul};        send_path();
        path_q = '{8'hF0, 8'h8F, 8'hBF, 8'hBF, upv_pkg::ByteNul}; send_path();
        path_q = '{8'hF4, 8'h90, 8'h80, 8'h80, upv_pkg::ByteNul}; send_path();
        path_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, upv_pkg::ByteNul}; send_path();
        path_q = '{8'hF5, 8'h80, 8'h80, 8'h80, upv_pkg::ByteNul}; send_path();
        path_q = '{8'hC3, upv_pkg::ByteNul};                      send_path();
        path_q = '{8'hC3, 8'h61, upv_pkg::ByteNul};               send_path();
        path_q = '{8'h80, upv_pkg::ByteNul};                      send_path();
        path_q = '{8'hC0, 8'hAF, 8'hFF, 8'hFE, upv_pkg::ByteNul}; send_path();
        wait_drained();

        write_mode(1'b1);
        send_text("/");
        send_text("/a/b");
        send_text("a");
        send_text("//");
        send_text("/a/");
        // The lone-slash rule looks at the mode seen with the terminator.
        path_q = '{upv_pkg::ByteSlash};
        send_path();
        wait_drained();
        write_mode(1'b0);
        path_q = '{upv_pkg::ByteNul};
        send_path();
        wait_drained();

        // Random phases, alternating the mode.
        for (int phase = 0; bytes_sent < RandomBytes; phase++) begin
            write_mode(phase[0]);
            gap_off = (phase % 5 == 4);
            if (phase == 2) long_hold_req = 1'b1;
            phase_start = bytes_sent;
            paused = 1'b0;
            while (bytes_sent - phase_start < PhaseBytes) begin
                pick = $urandom_range(0, 9);
                if (pick < 9) begin
                    make_good_path(phase[0]);
                    if (pick >= 7) break_path();
                end else begin
                    make_noise_path();
                end
                path_q.push_back(upv_pkg::ByteNul);
                send_path();
                if (phase == 3 && !paused && bytes_sent - phase_start >= PhaseBytes / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end
        gap_off = 1'b0;
        repeat (8) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
